### design/bfa_pkg.sv
// Shared types and constants for the bitmap frame allocator.
`timescale 1ns / 1ps
package bfa_pkg;

    localparam int ADDR_W     = 32;
    localparam int FRAME_SH   = 12;
    localparam int FRAME_W    = ADDR_W - FRAME_SH;
    localparam int END_W      = FRAME_W + 1;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [ADDR_W-1:0] NO_FRAME      = 32'hFFFF_FFFF;
    localparam logic [ADDR_W-1:0] USABLE_TYPE   = 32'd1;
    localparam logic [END_W-1:0]  LOW_RESERVED  = 21'd256;
    localparam logic [7:0]        BYTE_FULL     = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] REG_KSTART = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEND   = 1'd1;

    typedef enum logic [1:0] {
        CMD_ALLOC       = 2'd0,
        CMD_FREE        = 2'd1,
        CMD_ADD_REGION  = 2'd2,
        CMD_FINISH_INIT = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_RSTART,
        S_RANGE,
        S_RDRAIN,
        S_FIN
    } t_state;

    typedef struct packed {
        logic       is_first;
        logic       is_last;
        logic [2:0] lo;
        logic [2:0] hi;
        logic       used;
    } t_rmw_ctl;

endpackage

### design/bfa_cmd_if.sv
// Command channel: valid/ready handshake with the allocator command payload.
`timescale 1ns / 1ps
interface bfa_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] addr;
    logic [31:0] region_length;
    logic [31:0] region_type;

    modport source (output valid, output cmd, output addr, output region_length,
                    output region_type, input ready);
    modport sink   (input valid, input cmd, input addr, input region_length,
                    input region_type, output ready);
endinterface

### design/bfa_res_if.sv
// Result channel: valid/ready handshake with frame address and status.
`timescale 1ns / 1ps
interface bfa_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] page_addr;
    logic        status;

    modport source (output valid, output page_addr, output status, input ready);
    modport sink   (input valid, input page_addr, input status, output ready);
endinterface

### design/bitmap_frame_allocator_top.sv
// First-fit page frame allocator with one used bit per 4 KiB frame held in a byte-wide map.
`timescale 1ns / 1ps
// The used/free map lives in one byte-wide synchronous RAM of (NUM_FRAMES+7)/8 entries,
// one read and one write per cycle. After reset a clearing pass writes every byte to
// all-used; no command is taken during it, configuration writes are. Commands run one
// at a time and the RAM port sets the pace at one map byte per cycle: alloc reads bytes
// from the start up to the one holding the lowest free frame, or the whole map when it
// is full; free rewrites one byte; add_region rewrites the bytes a usable region spans;
// finish_init covers the low 32 bytes and then the kernel bytes. A result waits in an
// output register while the next command is taken.
module bitmap_frame_allocator_top #(
    parameter int NUM_FRAMES = 32768
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bfa_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bfa_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    bfa_cmd_if.sink                          i_cmd,
    bfa_res_if.source                        o_res
);
    import bfa_pkg::*;

    localparam int MAP_BYTES = (NUM_FRAMES + 7) / 8;
    localparam int AW        = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam logic [AW-1:0]    LAST_BYTE = AW'(MAP_BYTES - 1);
    localparam logic [END_W-1:0] N_FRAMES  = END_W'(NUM_FRAMES);

    // map storage
    logic [7:0]        r_map [MAP_BYTES];
    logic [7:0]        r_q;

    t_state            r_state,     n_state;
    logic [31:0]       r_kstart,    r_kend;
    logic [END_W-1:0]  r_first,     n_first;
    logic [END_W-1:0]  r_end,       n_end;
    logic              r_used,      n_used;
    logic              r_more,      n_more;
    logic              r_issued,    n_issued;
    logic [AW-1:0]     r_rd_byte,   n_rd_byte;
    logic              r_rd_v,      n_rd_v;
    logic [AW-1:0]     r_rd_b,      n_rd_b;
    logic [AW-1:0]     r_bfirst,    n_bfirst;
    logic [AW-1:0]     r_last,      n_last;
    logic [2:0]        r_lo,        n_lo;
    logic [2:0]        r_hi,        n_hi;
    logic [31:0]       r_res_addr,  n_res_addr;
    logic              r_res_status, n_res_status;
    logic              r_out_v,     n_out_v;
    logic [31:0]       r_out_addr,  n_out_addr;
    logic              r_out_status, n_out_status;

    logic              mem_rd_en;
    logic [AW-1:0]     mem_rd_addr;
    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    logic [7:0]        mem_wd;

    logic [END_W-1:0]  end_c;
    logic [END_W-1:0]  end_m1;
    logic [ADDR_W:0]   region_sum;

    t_rmw_ctl          rmw_ctl;
    logic [7:0]        range_data;
    logic              free_found;
    logic [2:0]        free_bit;
    logic [7:0]        alloc_data;

    assign end_c      = (r_end > N_FRAMES) ? N_FRAMES : r_end;
    assign end_m1     = end_c - END_W'(1);
    assign region_sum = {1'b0, i_cmd.addr} + {1'b0, i_cmd.region_length};

    assign rmw_ctl.is_first = (r_rd_b == r_bfirst);
    assign rmw_ctl.is_last  = (r_rd_b == r_last);
    assign rmw_ctl.lo       = r_lo;
    assign rmw_ctl.hi       = r_hi;
    assign rmw_ctl.used     = r_used;

    bfa_byte_rmw u_rmw (
        .i_data       (r_q),
        .i_ctl        (rmw_ctl),
        .o_range_data (range_data),
        .o_free_found (free_found),
        .o_free_bit   (free_bit),
        .o_alloc_data (alloc_data)
    );

    assign i_cmd.ready      = (r_state == S_IDLE);
    assign o_res.valid      = r_out_v;
    assign o_res.page_addr  = r_out_addr;
    assign o_res.status     = r_out_status;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_map[mem_wa] <= mem_wd;
        end
        if (mem_rd_en) begin
            r_q <= r_map[mem_rd_addr];
        end
    end

    always_comb begin
        n_state      = r_state;
        n_first      = r_first;
        n_end        = r_end;
        n_used       = r_used;
        n_more       = r_more;
        n_issued     = r_issued;
        n_rd_byte    = r_rd_byte;
        n_rd_v       = r_rd_v;
        n_rd_b       = r_rd_b;
        n_bfirst     = r_bfirst;
        n_last       = r_last;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        n_out_v      = r_out_v;
        n_out_addr   = r_out_addr;
        n_out_status = r_out_status;
        mem_rd_en    = 1'b0;
        mem_rd_addr  = r_rd_byte;
        mem_we       = 1'b0;
        mem_wa       = r_rd_b;
        mem_wd       = range_data;

        if (o_res.ready) begin
            n_out_v = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_rd_byte;
                mem_wd = BYTE_FULL;
                if (r_rd_byte == LAST_BYTE) begin
                    n_rd_byte = '0;
                    n_state   = S_IDLE;
                end else begin
                    n_rd_byte = r_rd_byte + AW'(1);
                end
            end
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_res_addr   = '0;
                    n_res_status = 1'b0;
                    n_rd_v       = 1'b0;
                    n_rd_byte    = '0;
                    n_issued     = 1'b0;
                    n_more       = 1'b0;
                    n_used       = 1'b0;
                    n_first      = {1'b0, i_cmd.addr[ADDR_W-1:FRAME_SH]};
                    unique case (t_cmd'(i_cmd.cmd))
                        CMD_ALLOC: begin
                            n_state = S_SCAN;
                        end
                        CMD_FREE: begin
                            n_end   = {1'b0, i_cmd.addr[ADDR_W-1:FRAME_SH]} + END_W'(1);
                            n_state = S_RSTART;
                        end
                        CMD_ADD_REGION: begin
                            n_end   = region_sum[ADDR_W:FRAME_SH];
                            n_state = (i_cmd.region_type == USABLE_TYPE) ? S_RSTART : S_FIN;
                        end
                        CMD_FINISH_INIT: begin
                            n_first = '0;
                            n_end   = LOW_RESERVED;
                            n_used  = 1'b1;
                            n_more  = 1'b1;
                            n_state = S_RSTART;
                        end
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_RSTART: begin
                priority if (r_first < end_c) begin
                    n_rd_byte = r_first[AW+2:3];
                    n_bfirst  = r_first[AW+2:3];
                    n_last    = end_m1[AW+2:3];
                    n_lo      = r_first[2:0];
                    n_hi      = end_m1[2:0];
                    n_state   = S_RANGE;
                end else if (r_more) begin
                    // advance to the kernel range
                    n_first = {1'b0, r_kstart[ADDR_W-1:FRAME_SH]};
                    n_end   = {1'b0, r_kend[ADDR_W-1:FRAME_SH]};
                    n_more  = 1'b0;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_RANGE: begin
                // read the next byte while the previous one is written back
                mem_rd_en = 1'b1;
                mem_we    = r_rd_v;
                n_rd_v    = 1'b1;
                n_rd_b    = r_rd_byte;
                if (r_rd_byte == r_last) begin
                    n_state = S_RDRAIN;
                end else begin
                    n_rd_byte = r_rd_byte + AW'(1);
                end
            end
            S_RDRAIN: begin
                mem_we = 1'b1;
                n_rd_v = 1'b0;
                if (r_more) begin
                    n_first = {1'b0, r_kstart[ADDR_W-1:FRAME_SH]};
                    n_end   = {1'b0, r_kend[ADDR_W-1:FRAME_SH]};
                    n_more  = 1'b0;
                    n_state = S_RSTART;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_SCAN: begin
                priority if (r_rd_v && free_found) begin
                    mem_we       = 1'b1;
                    mem_wd       = alloc_data;
                    n_res_addr   = 32'({r_rd_b, free_bit, 12'h000});
                    n_res_status = 1'b0;
                    n_rd_v       = 1'b0;
                    n_state      = S_FIN;
                end else if (r_rd_v && (r_rd_b == LAST_BYTE)) begin
                    n_res_addr   = NO_FRAME;
                    n_res_status = 1'b1;
                    n_rd_v       = 1'b0;
                    n_state      = S_FIN;
                end else begin
                    mem_rd_en = !r_issued;
                    n_rd_v    = !r_issued;
                    n_rd_b    = r_rd_byte;
                    if (!r_issued) begin
                        if (r_rd_byte == LAST_BYTE) begin
                            n_issued = 1'b1;
                        end else begin
                            n_rd_byte = r_rd_byte + AW'(1);
                        end
                    end
                end
            end
            S_FIN: begin
                // hold until the output register is free
                if (!r_out_v || o_res.ready) begin
                    n_out_v      = 1'b1;
                    n_out_addr   = r_res_addr;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_rd_byte <= '0;
            r_rd_v    <= 1'b0;
            r_out_v   <= 1'b0;
            r_more    <= 1'b0;
            r_issued  <= 1'b0;
            r_kstart  <= '0;
            r_kend    <= '0;
        end else begin
            r_state   <= n_state;
            r_rd_byte <= n_rd_byte;
            r_rd_v    <= n_rd_v;
            r_out_v   <= n_out_v;
            r_more    <= n_more;
            r_issued  <= n_issued;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_KSTART: r_kstart <= i_cfg_data;
                    REG_KEND:   r_kend   <= i_cfg_data;
                    default:    r_kend   <= r_kend;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_first      <= n_first;
        r_end        <= n_end;
        r_used       <= n_used;
        r_rd_b       <= n_rd_b;
        r_bfirst     <= n_bfirst;
        r_last       <= n_last;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
        r_out_addr   <= n_out_addr;
        r_out_status <= n_out_status;
    end

endmodule

### design/bfa_byte_rmw.sv
// Modify logic for one map byte: range set/clear mask and lowest-free-bit pick.
`timescale 1ns / 1ps
module bfa_byte_rmw (
    input  logic              [7:0] i_data,
    input  bfa_pkg::t_rmw_ctl       i_ctl,
    output logic              [7:0] o_range_data,
    output logic                    o_free_found,
    output logic              [2:0] o_free_bit,
    output logic              [7:0] o_alloc_data
);
    import bfa_pkg::*;

    logic [2:0] lo;
    logic [2:0] hi;
    logic [7:0] mask;

    assign lo = i_ctl.is_first ? i_ctl.lo : 3'd0;
    assign hi = i_ctl.is_last  ? i_ctl.hi : 3'd7;

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            mask[k] = (3'(k) >= lo) && (3'(k) <= hi);
        end
    end

    assign o_range_data = i_ctl.used ? (i_data | mask) : (i_data & ~mask);

    // Lowest clear bit wins.
    always_comb begin
        o_free_bit = 3'd0;
        for (int k = 7; k >= 0; k--) begin
            if (!i_data[k]) begin
                o_free_bit = 3'(k);
            end
        end
    end

    assign o_free_found = (i_data != BYTE_FULL);
    assign o_alloc_data = i_data | (8'd1 << o_free_bit);

endmodule
